// ===== src/swld_pkg.sv =====
// Package with the shared types and constants of the sync word length deframer.
package swld_pkg;

   // Frame phase of the deframer. The unused code is treated as hunting.
   typedef enum logic [1:0] {
      PHASE_HUNT    = 2'd0,
      PHASE_LENGTH  = 2'd1,
      PHASE_PAYLOAD = 2'd2
   } phase_type;

   localparam int BYTE_W    = 8;
   localparam int LENGTH_W  = 32;
   localparam int PAYLOAD_W = 24;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register index of max_payload, taken from paddr bit 2.
   localparam logic CSR_IDX_MAX_PAYLOAD = 1'b0;

   localparam logic [PAYLOAD_W-1:0] MAX_PAYLOAD_RESET = 24'd65535;

   // Last index of the sync word and of the length field.
   localparam logic [1:0] SYNC_LAST   = 2'd3;
   localparam logic [1:0] LENGTH_LAST = 2'd3;

   // Sync word "TRAJ", one byte per match position.
   function automatic logic [BYTE_W-1:0] sync_byte(input logic [1:0] idx);
      logic [BYTE_W-1:0] b;
      case (idx)
         2'd0:    b = 8'h54;
         2'd1:    b = 8'h52;
         2'd2:    b = 8'h41;
         default: b = 8'h4A;
      endcase
      return b;
   endfunction

   // One result transaction as it leaves the parser.
   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] out_byte;
      logic              frame_start;
      logic              frame_end;
      logic              length_error;
   } result_type;

endpackage

// ===== src/swld_parser.sv =====
// Frame parser: sync hunt, length field capture and payload countdown for one byte per step.
module swld_parser (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               step,
   input  logic [swld_pkg::BYTE_W-1:0]        in_byte,
   input  logic [swld_pkg::PAYLOAD_W-1:0]     max_payload,
   output swld_pkg::result_type               result
);

   swld_pkg::phase_type               phase_ff, phase_in;
   logic [1:0]                        sync_matched_ff, sync_matched_in;
   logic [1:0]                        len_seen_ff, len_seen_in;
   logic [swld_pkg::LENGTH_W-1:0]     len_accum_ff, len_accum_in;
   logic [swld_pkg::PAYLOAD_W-1:0]    payload_left_ff, payload_left_in;

   logic [swld_pkg::LENGTH_W-1:0]     new_accum;
   logic [swld_pkg::PAYLOAD_W-1:0]    left_dec;
   logic                              sync_hit;
   logic                              last_len;
   logic                              too_big;
   logic                              len_zero;
   logic                              payload_done;

   // Shared decode of the current byte.
   assign new_accum    = {len_accum_ff[swld_pkg::LENGTH_W-swld_pkg::BYTE_W-1:0], in_byte};
   assign left_dec     = payload_left_ff - swld_pkg::PAYLOAD_W'(1);
   assign sync_hit     = (in_byte == swld_pkg::sync_byte(sync_matched_ff));
   assign last_len     = (len_seen_ff == swld_pkg::LENGTH_LAST);
   assign too_big      = (new_accum > {{(swld_pkg::LENGTH_W-swld_pkg::PAYLOAD_W){1'b0}},
                                       max_payload});
   assign len_zero     = (new_accum == '0);
   assign payload_done = (left_dec == '0);

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         swld_pkg::PHASE_LENGTH: begin
            if (last_len) begin
               phase_in = (too_big || len_zero) ? swld_pkg::PHASE_HUNT
                                                : swld_pkg::PHASE_PAYLOAD;
            end
         end
         swld_pkg::PHASE_PAYLOAD: begin
            if (payload_done) begin
               phase_in = swld_pkg::PHASE_HUNT;
            end
         end
         default: begin
            phase_in = (sync_hit && sync_matched_ff == swld_pkg::SYNC_LAST)
                       ? swld_pkg::PHASE_LENGTH : swld_pkg::PHASE_HUNT;
         end
      endcase
   end

   // Counters, length accumulator and the result of this byte.
   always_comb begin
      sync_matched_in     = sync_matched_ff;
      len_seen_in         = len_seen_ff;
      len_accum_in        = len_accum_ff;
      payload_left_in     = payload_left_ff;
      result.valid        = 1'b0;
      result.out_byte     = in_byte;
      result.frame_start  = 1'b0;
      result.frame_end    = 1'b0;
      result.length_error = 1'b0;
      unique case (phase_ff)
         swld_pkg::PHASE_LENGTH: begin
            result.valid       = step;
            result.frame_start = (len_seen_ff == 2'd0);
            len_seen_in        = len_seen_ff + 2'd1;
            len_accum_in       = new_accum;
            if (last_len) begin
               if (too_big || len_zero) begin
                  result.frame_end    = 1'b1;
                  result.length_error = too_big;
                  len_accum_in        = '0;
               end else begin
                  payload_left_in = new_accum[swld_pkg::PAYLOAD_W-1:0];
               end
            end
         end
         swld_pkg::PHASE_PAYLOAD: begin
            result.valid    = step;
            payload_left_in = left_dec;
            if (payload_done) begin
               result.frame_end = 1'b1;
               len_seen_in      = '0;
               len_accum_in     = '0;
            end
         end
         default: begin
            // A byte that breaks a partial match restarts it, counting a 'T'.
            if (sync_hit) begin
               if (sync_matched_ff == swld_pkg::SYNC_LAST) begin
                  sync_matched_in = '0;
                  len_seen_in     = '0;
                  len_accum_in    = '0;
                  payload_left_in = '0;
               end else begin
                  sync_matched_in = sync_matched_ff + 2'd1;
               end
            end else begin
               sync_matched_in = (in_byte == swld_pkg::sync_byte(2'd0)) ? 2'd1 : 2'd0;
            end
         end
      endcase
   end

   // State registers advance only when a byte is processed.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= swld_pkg::PHASE_HUNT;
         sync_matched_ff <= '0;
         len_seen_ff     <= '0;
         len_accum_ff    <= '0;
         payload_left_ff <= '0;
      end else if (step) begin
         phase_ff        <= phase_in;
         sync_matched_ff <= sync_matched_in;
         len_seen_ff     <= len_seen_in;
         len_accum_ff    <= len_accum_in;
         payload_left_ff <= payload_left_in;
      end
   end

endmodule

// ===== src/sync_word_length_deframer.sv =====
// An accepted input byte is held in the input register, then its result in the result
// register on the rsp_ side. Throughput: one byte per cycle unless the result side stalls;
// the two registers decouple the channels, and the parser updates its state and counter
// once per byte. Bytes dropped while hunting give no result transaction.
// Reset is synchronous and active high: it empties both registers, returns the parser
// to hunting and sets max_payload to 65535.
module sync_word_length_deframer (
   input  logic                                clock,
   input  logic                                reset,
   // Input channel.
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [swld_pkg::BYTE_W-1:0]         req_in_byte,
   // Result channel.
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [swld_pkg::BYTE_W-1:0]         rsp_out_byte,
   output logic                                rsp_frame_start,
   output logic                                rsp_frame_end,
   output logic                                rsp_length_error,
   // Configuration port.
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [swld_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [swld_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [swld_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   logic [swld_pkg::PAYLOAD_W-1:0] max_payload_ff;
   logic                           in_valid_ff;
   logic [swld_pkg::BYTE_W-1:0]    in_byte_ff;
   logic                           rsp_valid_ff;
   swld_pkg::result_type           rsp_ff;
   swld_pkg::result_type           result;
   logic                           out_free;
   logic                           step;
   logic                           req_take;

   // Configuration register.
   assign csr_pready = 1'b1;
   assign csr_prdata = {{(swld_pkg::CSR_DATA_W-swld_pkg::PAYLOAD_W){1'b0}}, max_payload_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= swld_pkg::MAX_PAYLOAD_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr[2] == swld_pkg::CSR_IDX_MAX_PAYLOAD) begin
         max_payload_ff <= csr_pwdata[swld_pkg::PAYLOAD_W-1:0];
      end
   end

   // Handshake: the held byte is processed whenever the result register can take it.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (step) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_in_byte;
      end
   end

   swld_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .in_byte     (in_byte_ff),
      .max_payload (max_payload_ff),
      .result      (result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = rsp_ff.out_byte;
   assign rsp_frame_start  = rsp_ff.frame_start;
   assign rsp_frame_end    = rsp_ff.frame_end;
   assign rsp_length_error = rsp_ff.length_error;

   // A rejected length always closes the frame.
   a_error_ends_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.length_error |-> rsp_ff.frame_end)
      else $error("length error without frame end");

   // The first length byte can never also be the last byte of a frame.
   a_start_not_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.frame_start |-> !rsp_ff.frame_end)
      else $error("frame start and frame end on the same byte");

   // A byte is never processed while a stalled result is still held.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> !step)
      else $error("parser stepped over a stalled result");

   // The input side stalls only when a byte is held.
   a_stall_held: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("input stalled with an empty input register");

endmodule

// ===== verif/tb_sync_word_length_deframer.sv =====
// Self-checking testbench for the sync word length deframer, run on random byte streams.
module tb_sync_word_length_deframer;

   localparam int CLOCK_HALF   = 4;
   localparam int RESET_CYCLES = 12;
   localparam int DRAIN_CYCLES = 8;
   localparam int STALL_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 300;
   localparam int HOLD_AFTER   = 150;
   localparam int PHASE_ITEMS  = 360;
   localparam int MAX_SHORT    = 24;

   localparam logic [swld_pkg::CSR_ADDR_W-1:0] ADDR_MAX_PAYLOAD =
      {swld_pkg::CSR_IDX_MAX_PAYLOAD, 2'b00};
   localparam logic [31:0] TRAJ_WORD = 32'h5452414A;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_COIN,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   // One deframed byte as it is expected on the rsp_ side.
   typedef struct packed {
      logic [swld_pkg::BYTE_W-1:0] out_byte;
      logic                        frame_start;
      logic                        frame_end;
      logic                        length_error;
   } deframed_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic [swld_pkg::BYTE_W-1:0]     req_in_byte = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic [swld_pkg::BYTE_W-1:0]     rsp_out_byte;
   logic                            rsp_frame_start;
   logic                            rsp_frame_end;
   logic                            rsp_length_error;
   logic                            csr_psel = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite = 1'b0;
   logic [swld_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [swld_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [swld_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   // Byte stream waiting to be sent and deframed bytes waiting to come back.
   logic [swld_pkg::BYTE_W-1:0] pending_bytes[$];
   deframed_type                expected_bytes[$];

   // Predictor state and its copy of the payload limit.
   swld_pkg::phase_type            model_phase;
   logic [1:0]                     model_sync;
   logic [1:0]                     model_len_seen;
   logic [swld_pkg::LENGTH_W-1:0]  model_len;
   logic [swld_pkg::PAYLOAD_W-1:0] model_left;
   logic [swld_pkg::PAYLOAD_W-1:0] payload_limit;

   int mismatches      = 0;
   int results_checked = 0;
   int frames_seen     = 0;
   int length_errors   = 0;
   int settings_count  = 0;
   int queued_items    = 0;
   int idle_cycles     = 0;
   int burst_left      = 0;
   int gap_left        = 0;
   int hold_left       = 0;
   int mode_left       = 0;
   logic hold_done     = 1'b0;
   logic byte_taken    = 1'b0;
   stall_mode_type stall_mode = STALL_NONE;

   sync_word_length_deframer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_frame_start  (rsp_frame_start),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_length_error (rsp_length_error),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   initial begin
      forever #CLOCK_HALF clock = ~clock;
   end

   // Returns the predictor to hunting with all frame state cleared.
   function automatic void restart_hunt();
      model_phase    = swld_pkg::PHASE_HUNT;
      model_sync     = 2'd0;
      model_len_seen = 2'd0;
      model_len      = '0;
      model_left     = '0;
   endfunction

   // Advances the predictor by one stream byte and queues the deframed byte, if any.
   task automatic deframe_byte(input logic [swld_pkg::BYTE_W-1:0] b);
      deframed_type                r;
      logic                        last;
      logic [swld_pkg::BYTE_W-1:0] want;
      r.out_byte     = b;
      r.frame_start  = 1'b0;
      r.frame_end    = 1'b0;
      r.length_error = 1'b0;
      case (model_phase)
         swld_pkg::PHASE_LENGTH: begin
            r.frame_start  = (model_len_seen == 2'd0);
            last           = (model_len_seen == swld_pkg::LENGTH_LAST);
            model_len      = {model_len[swld_pkg::LENGTH_W-swld_pkg::BYTE_W-1:0], b};
            model_len_seen = model_len_seen + 2'd1;
            if (last) begin
               if (model_len > {8'd0, payload_limit}) begin
                  r.frame_end    = 1'b1;
                  r.length_error = 1'b1;
                  restart_hunt();
               end else if (model_len == '0) begin
                  r.frame_end = 1'b1;
                  restart_hunt();
               end else begin
                  model_left  = model_len[swld_pkg::PAYLOAD_W-1:0];
                  model_phase = swld_pkg::PHASE_PAYLOAD;
               end
            end
            expected_bytes.push_back(r);
         end
         swld_pkg::PHASE_PAYLOAD: begin
            model_left = model_left - 1'b1;
            if (model_left == '0) begin
               r.frame_end = 1'b1;
               restart_hunt();
            end
            expected_bytes.push_back(r);
         end
         default: begin
            // Hunting: a byte that breaks a partial match may itself start a new one.
            want        = TRAJ_WORD[8*(3-int'(model_sync)) +: 8];
            model_phase = swld_pkg::PHASE_HUNT;
            if (b == want) begin
               if (model_sync == swld_pkg::SYNC_LAST) begin
                  restart_hunt();
                  model_phase = swld_pkg::PHASE_LENGTH;
               end else begin
                  model_sync = model_sync + 2'd1;
               end
            end else begin
               model_sync = (b == TRAJ_WORD[31:24]) ? 2'd1 : 2'd0;
            end
         end
      endcase
   endtask

   // Queues a sync word, a big-endian length field and random payload bytes, which may begin with the sync word.
   task automatic queue_frame(input logic [31:0] len_field, input int payload_count,
                              input logic embed_sync);
      logic [swld_pkg::BYTE_W-1:0] data;
      for (int i = 0; i < 4; i++) pending_bytes.push_back(TRAJ_WORD[31-8*i -: 8]);
      for (int i = 0; i < 4; i++) pending_bytes.push_back(len_field[31-8*i -: 8]);
      for (int i = 0; i < payload_count; i++) begin
         data = swld_pkg::BYTE_W'($urandom);
         if (embed_sync && i < 4) data = TRAJ_WORD[31-8*i -: 8];
         pending_bytes.push_back(data);
      end
      queued_items += 8 + payload_count;
   endtask

   // Mostly well-formed frames, plus rejected lengths, broken sync words and noise.
   task automatic queue_random_traffic(input int target);
      int                             pick;
      int                             count;
      int                             cap;
      logic [31:0]                    len;
      logic [swld_pkg::BYTE_W-1:0]    top;
      logic [swld_pkg::PAYLOAD_W-1:0] rest;
      logic [swld_pkg::BYTE_W-1:0]    data;
      while (queued_items < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 65) begin
            cap   = (payload_limit < MAX_SHORT) ? int'(payload_limit) : MAX_SHORT;
            count = $urandom_range(0, 19);
            if (cap == 0 || count == 0) len = '0;
            else if (count == 1) len = cap;
            else len = $urandom_range(1, cap);
            queue_frame(len, int'(len), $urandom_range(0, 7) == 0);
         end else if (pick < 80) begin
            top  = swld_pkg::BYTE_W'($urandom_range(1, 255));
            rest = swld_pkg::PAYLOAD_W'($urandom);
            if ($urandom_range(0, 1) == 0)
               len = {8'd0, payload_limit} + 32'd1 + $urandom_range(0, 2);
            else
               len = {top, rest};
            queue_frame(len, 0, 1'b0);
         end else if (pick < 90) begin
            count = $urandom_range(1, 3);
            for (int i = 0; i < count; i++) pending_bytes.push_back(TRAJ_WORD[31-8*i -: 8]);
            data = swld_pkg::BYTE_W'($urandom);
            pending_bytes.push_back(data);
            queued_items += count + 1;
         end else begin
            count = $urandom_range(1, 6);
            repeat (count) begin
               data = swld_pkg::BYTE_W'($urandom);
               pending_bytes.push_back(data);
            end
            queued_items += count;
         end
      end
   endtask

   // Waits until every byte is sent and every deframed byte has come back, then lets
   // hunted bytes still in flight clear the pipeline.
   task automatic wait_idle();
      while (pending_bytes.size() != 0 || req_valid || expected_bytes.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes max_payload with random upper bits, then reads it back.
   task automatic set_payload_limit(input logic [swld_pkg::PAYLOAD_W-1:0] value);
      logic [7:0] junk;
      junk = 8'($urandom);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_MAX_PAYLOAD;
      csr_pwdata  <= {junk, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      payload_limit = value;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[swld_pkg::PAYLOAD_W-1:0] !== value) begin
         mismatches++;
         $display("%0t: max_payload read back expected %h actual %h", $time, value,
                  csr_prdata[swld_pkg::PAYLOAD_W-1:0]);
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      settings_count++;
      queued_items = 0;
      @(posedge clock);
   endtask

   // Sender acceptance: every transaction taken by the block advances the predictor.
   always @(posedge clock) begin
      byte_taken = !reset && req_valid && !req_stall;
      if (byte_taken) deframe_byte(req_in_byte);
   end

   // Sender: bursts of random length with random gaps, fed from the pending queue.
   always @(negedge clock) begin : sender
      logic                        next_valid;
      logic [swld_pkg::BYTE_W-1:0] next_byte;
      next_valid = req_valid;
      next_byte  = req_in_byte;
      if (reset) begin
         next_valid = 1'b0;
      end else begin
         if (req_valid && byte_taken) next_valid = 1'b0;
         if (!next_valid && pending_bytes.size() != 0) begin
            if (gap_left > 0) begin
               gap_left--;
            end else begin
               next_byte  = pending_bytes.pop_front();
               next_valid = 1'b1;
               if (burst_left > 0) burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end
         end
      end
      req_valid   <= next_valid;
      req_in_byte <= next_byte;
   end

   // Receiver: changing stall patterns, and one long hold-off that backs up the block.
   always @(negedge clock) begin : receiver
      logic stall_next;
      stall_next = 1'b0;
      if (hold_left > 0) begin
         hold_left--;
         stall_next = 1'b1;
      end else if (!hold_done && results_checked >= HOLD_AFTER) begin
         hold_done  = 1'b1;
         hold_left  = HOLD_CYCLES - 1;
         stall_next = 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(8, 64);
         end
         mode_left--;
         case (stall_mode)
            STALL_NONE:  stall_next = 1'b0;
            STALL_COIN:  stall_next = ($urandom_range(0, 1) == 0);
            STALL_HEAVY: stall_next = ($urandom_range(0, 3) != 0);
            default:     stall_next = (mode_left % 3 == 0);
         endcase
      end
      rsp_stall <= stall_next;
   end

   // Monitor: each result transaction is compared with the oldest expected byte.
   always @(posedge clock) begin : monitor
      deframed_type want;
      deframed_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.out_byte     = rsp_out_byte;
         got.frame_start  = rsp_frame_start;
         got.frame_end    = rsp_frame_end;
         got.length_error = rsp_length_error;
         if (expected_bytes.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result byte=%h start=%b end=%b err=%b", $time,
                     got.out_byte, got.frame_start, got.frame_end, got.length_error);
         end else begin
            want = expected_bytes.pop_front();
            results_checked++;
            if (want.frame_start) frames_seen++;
            if (want.length_error) length_errors++;
            if (got !== want) begin
               mismatches++;
               $display({"%0t: expected byte=%h start=%b end=%b err=%b",
                         " actual byte=%h start=%b end=%b err=%b"},
                        $time, want.out_byte, want.frame_start, want.frame_end,
                        want.length_error, got.out_byte, got.frame_start, got.frame_end,
                        got.length_error);
            end
         end
      end
   end

   // Watchdog: ends the run when no transaction moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
         $display("FAILURE");
         $finish;
      end
   end

   // Phases of the run, each under its own payload limit.
   initial begin
      restart_hunt();
      payload_limit  = swld_pkg::MAX_PAYLOAD_RESET;
      settings_count = 1;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (DRAIN_CYCLES) @(posedge clock);

      // Reset limit: a sync word after a broken match, an empty frame and a payload
      // that carries the sync word.
      pending_bytes.push_back(TRAJ_WORD[31:24]);
      pending_bytes.push_back(TRAJ_WORD[23:16]);
      queued_items += 2;
      queue_frame(32'd0, 0, 1'b0);
      queue_frame(32'd4, 4, 1'b1);
      queue_random_traffic(PHASE_ITEMS);
      wait_idle();

      // Zero limit: only empty frames pass.
      set_payload_limit(24'd0);
      queue_frame(32'd0, 0, 1'b0);
      queue_frame(32'd1, 0, 1'b0);
      queue_random_traffic(PHASE_ITEMS);
      wait_idle();

      // Largest limit: only lengths with the top byte set are rejected.
      set_payload_limit(24'hFFFFFF);
      queue_frame(32'hFFFFFFFF, 0, 1'b0);
      queue_frame(32'h01000000, 0, 1'b0);
      queue_random_traffic(PHASE_ITEMS);
      wait_idle();

      // Small limit: lengths on both sides of the boundary.
      set_payload_limit(24'd3);
      queue_frame(32'd3, 3, 1'b0);
      queue_frame(32'd4, 0, 1'b0);
      queue_random_traffic(PHASE_ITEMS);
      wait_idle();

      // Random small limit.
      set_payload_limit(swld_pkg::PAYLOAD_W'($urandom_range(1, 64)));
      queue_random_traffic(PHASE_ITEMS);
      wait_idle();

      $display("Checked %0d deframed bytes in %0d frames, %0d rejected, under %0d limits.",
               results_checked, frames_seen, length_errors, settings_count);
      $display("Sender bursts, receiver stall patterns and a %0d-cycle hold-off were run.",
               HOLD_CYCLES);
      if (mismatches == 0 && expected_bytes.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
